[design/instruction_byte_encoder_core_assert.svh]
// Assertion macros used by the checker file.
`ifndef INSTRUCTION_BYTE_ENCODER_CORE_ASSERT_SVH
`define INSTRUCTION_BYTE_ENCODER_CORE_ASSERT_SVH

// Plain property check, clocked and held off during reset.
`define IBE_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Condition in one cycle implies consequence in the next.
`define IBE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	`IBE_ASSERT(name, clk, rst_n, (ante) |=> (cons), msg)

`endif

[design/ibe_pkg.sv]
package ibe_pkg;

	// Operand kinds on the request side
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_REG  = 2'd1,
		KIND_IMM  = 2'd2,
		KIND_BAD  = 2'd3
	} kind_t;

	// Operand type codes in the machine code
	localparam logic [1:0] TYPE_REG  = 2'b00;
	localparam logic [1:0] TYPE_IMM1 = 2'b10;
	localparam logic [1:0] TYPE_IMM2 = 2'b11;

	localparam int OPCODE_W  = 6;
	localparam int REG_W     = 3;
	localparam int IMM_W     = 16;
	localparam int MAX_BYTES = 4;
	localparam int IDX_W     = $clog2(MAX_BYTES);

	typedef logic [7:0] byte_t;

	// One instruction as held in the input register
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		kind_t               first_kind;
		kind_t               second_kind;
		logic [REG_W-1:0]    first_reg;
		logic [REG_W-1:0]    second_reg;
		logic [IMM_W-1:0]    immediate_value;
	} item_t;

	// Encoded instruction: bytes in emission order and index of the last one
	typedef struct packed {
		byte_t [MAX_BYTES-1:0] bytes;
		logic [IDX_W-1:0]      last_idx;
		logic                  bad;
	} enc_t;

	// Handoff between input register and output stage
	typedef struct packed {
		logic done;
	} ctl_t;

endpackage

[design/ibe_in_stage.sv]
module ibe_in_stage
	import ibe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [1:0]          first_kind,
	input  logic [1:0]          second_kind,
	input  logic [REG_W-1:0]    first_reg,
	input  logic [REG_W-1:0]    second_reg,
	input  logic [IMM_W-1:0]    immediate_value,
	input  logic                done,
	output item_t               item_s1,
	output logic                valid_s1
);

	logic accept;

	// Free when empty or when the held request sends its last byte now
	assign in_ready = !valid_s1 || done;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !done);
		end
	end

	// Payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode          <= opcode;
			item_s1.first_kind      <= kind_t'(first_kind);
			item_s1.second_kind     <= kind_t'(second_kind);
			item_s1.first_reg       <= first_reg;
			item_s1.second_reg      <= second_reg;
			item_s1.immediate_value <= immediate_value;
		end
	end

endmodule

[design/ibe_encode.sv]
module ibe_encode
	import ibe_pkg::*;
(
	input  item_t item,
	output enc_t  enc
);

	byte_t      lo;
	byte_t      hi;
	logic       hi_nz;
	logic [1:0] itype;
	logic [1:0] imm_last;
	logic [1:0] regs_last;
	kind_t      k0;
	kind_t      k1;

	assign k0       = item.first_kind;
	assign k1       = item.second_kind;
	assign lo       = item.immediate_value[7:0];
	assign hi       = item.immediate_value[15:8];
	assign hi_nz    = |hi;
	assign itype    = hi_nz ? TYPE_IMM2 : TYPE_IMM1;
	// last index when immediate starts at byte 1 or byte 2
	assign imm_last  = hi_nz ? 2'd2 : 2'd1;
	assign regs_last = hi_nz ? 2'd3 : 2'd2;

	// Byte layout per operand mix
	always_comb begin
		enc.bytes    = '0;
		enc.last_idx = '0;
		enc.bad      = 1'b0;
		if (k0 == KIND_NONE && k1 == KIND_NONE) begin
			enc.bytes[0] = {item.opcode, TYPE_REG};
		end else if (k0 == KIND_REG && k1 == KIND_NONE) begin
			enc.bytes[0] = {item.opcode, TYPE_REG};
			enc.bytes[1] = {2'b00, item.first_reg, 3'b000};
			enc.last_idx = 2'd1;
		end else if (k0 == KIND_IMM && k1 == KIND_NONE) begin
			enc.bytes[0] = {item.opcode, itype};
			enc.bytes[1] = lo;
			enc.bytes[2] = hi;
			enc.last_idx = imm_last;
		end else if (k0 == KIND_REG && k1 == KIND_REG) begin
			enc.bytes[0] = {item.opcode, TYPE_REG};
			enc.bytes[1] = {TYPE_REG, item.first_reg, item.second_reg};
			enc.last_idx = 2'd1;
		end else if (k0 == KIND_REG && k1 == KIND_IMM) begin
			enc.bytes[0] = {item.opcode, TYPE_REG};
			enc.bytes[1] = {itype, item.first_reg, 3'b000};
			enc.bytes[2] = lo;
			enc.bytes[3] = hi;
			enc.last_idx = regs_last;
		end else if (k0 == KIND_IMM && k1 == KIND_REG) begin
			enc.bytes[0] = {item.opcode, itype};
			enc.bytes[1] = {TYPE_REG, 3'b000, item.second_reg};
			enc.bytes[2] = lo;
			enc.bytes[3] = hi;
			enc.last_idx = regs_last;
		end else begin
			// invalid mix: single zero byte flagged bad
			enc.bad = 1'b1;
		end
	end

endmodule

[design/ibe_out_stage.sv]
module ibe_out_stage
	import ibe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  enc_t  enc,
	output ctl_t  ctl,
	input  logic  valid_s1,
	output logic  out_valid,
	input  logic  out_ready,
	output byte_t code_byte,
	output logic  last_byte,
	output logic  bad_operands
);

	logic [IDX_W-1:0] idx_q;
	logic             load;
	logic             at_last;

	// Output register takes a byte whenever a request is held and it is empty or being drained
	assign load      = valid_s1 && (!out_valid || out_ready);
	assign at_last   = (idx_q == enc.last_idx);
	assign ctl.done  = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q     <= at_last ? '0 : idx_q + 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Byte payload
	always_ff @(posedge clk) begin
		if (load) begin
			code_byte    <= enc.bytes[idx_q];
			last_byte    <= at_last;
			bad_operands <= enc.bad;
		end
	end

endmodule

[design/instruction_byte_encoder_core.sv]
// A request is held in the input register, encoded, and its bytes are loaded into the output register.
// Throughput: one byte per cycle while out_ready does not stall the output; an instruction
// emits 1 to 4 machine-code bytes, picked by the byte select into the output register.
// A new request is taken in the cycle its predecessor's last byte loads.
// Reset (arst_n low) clears the valid flags and the byte index at once.
module instruction_byte_encoder_core
	import ibe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [1:0]          first_kind,
	input  logic [1:0]          second_kind,
	input  logic [REG_W-1:0]    first_reg,
	input  logic [REG_W-1:0]    second_reg,
	input  logic [IMM_W-1:0]    immediate_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          code_byte,
	output logic                last_byte,
	output logic                bad_operands
);

	item_t item_s1;
	logic  valid_s1;
	enc_t  enc;
	ctl_t  ctl;

	ibe_in_stage u_in (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.first_kind      (first_kind),
		.second_kind     (second_kind),
		.first_reg       (first_reg),
		.second_reg      (second_reg),
		.immediate_value (immediate_value),
		.done            (ctl.done),
		.item_s1         (item_s1),
		.valid_s1        (valid_s1)
	);

	ibe_encode u_enc (
		.item (item_s1),
		.enc  (enc)
	);

	ibe_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.enc          (enc),
		.ctl          (ctl),
		.valid_s1     (valid_s1),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.code_byte    (code_byte),
		.last_byte    (last_byte),
		.bad_operands (bad_operands)
	);

endmodule

[design/ibe_chk.sv]
`include "instruction_byte_encoder_core_assert.svh"

module ibe_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [5:0] opcode,
	input logic [1:0] first_kind,
	input logic [1:0] second_kind,
	input logic [2:0] first_reg,
	input logic [2:0] second_reg,
	input logic [15:0] immediate_value,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] code_byte,
	input logic       last_byte,
	input logic       bad_operands
);

	// A stalled byte stays put
	`IBE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(code_byte) && $stable(last_byte), "output byte changed while stalled")

	// An error result is a single zero byte
	`IBE_ASSERT(a_bad_single, clk, arst_n, (out_valid && bad_operands) |-> (last_byte && code_byte == 8'd0), "bad result not a lone zero byte")

	// Bytes before the last of an instruction never carry the error flag
	`IBE_ASSERT(a_bad_not_mid, clk, arst_n, (out_valid && !last_byte) |-> !bad_operands, "error flag on a middle byte")

	// The byte after a taken middle byte is not an error result
	`IBE_ASSERT_NEXT(a_mid_follow, clk, arst_n, out_valid && out_ready && !last_byte, !out_valid || !bad_operands, "error result inside an instruction")

endmodule

bind instruction_byte_encoder_core ibe_chk u_ibe_chk (.*);
